/* rtl/core/vms_pkg.sv */
// Vector magnitude statistics: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package vms_pkg;
    localparam int CompW = 16;
    localparam int SqW   = 33;
    localparam int MagW  = 16;
    localparam int SumW  = 40;
    localparam int SsqW  = 56;
    localparam int CntW  = 25;
    localparam int DW    = 97;

    typedef struct packed {
        logic [MagW-1:0] mn;
        logic [MagW-1:0] mx;
        logic [SumW-1:0] sum;
        logic [SsqW-1:0] ssq;
        logic [CntW-1:0] n;
    } t_stats;

    typedef struct packed {
        logic [MagW-1:0] min_mag;
        logic [MagW-1:0] max_mag;
        logic [MagW-1:0] mean_mag;
        logic [MagW-1:0] std_dev;
    } t_result;
endpackage

/* rtl/core/vector_magnitude_statistics_core.sv */
// Top level of vector magnitude statistics: front root/accumulate pipeline,
// back mean/std-dev sequencer. Uses vms_pkg, vms_front, vms_back.
`timescale 1ns / 1ps
// Usage:
//  Input channel is a queue: drive i_vec_x/y/z and i_last with push; a word
//  is taken at a clock edge with push high and full low.
//  Result channel is a queue: while empty is low the ports carry the oldest
//  result; it leaves on an edge with pop high.
//  Front: one word per cycle while not full into a pipeline (squares, 16 root
//  stages, accumulate). A word marked last hands a snapshot of the statistics
//  to a one-entry buffer and the accumulators clear in the same cycle.
//  Back: the bit-serial products and the 40-step mean division come first,
//  then the std-dev root takes 16 passes, each squaring a trial root with the
//  serial shift-add multiplier.
//  Words are accepted at one per cycle; the front stalls (full) only when a
//  last word reaches the end of its pipeline while an earlier snapshot still
//  waits for the back.
//  A stalled result receiver holds the output register; the back then holds
//  its finished result and stops taking snapshots.
//  Synchronous active-low reset clears the valid flags, the back state and the running statistics.
module vector_magnitude_statistics_core
    import vms_pkg::*;
#(
    parameter int MAX_POINTS = 16777216
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [CompW-1:0] i_vec_x,
    input  logic signed [CompW-1:0] i_vec_y,
    input  logic signed [CompW-1:0] i_vec_z,
    input  logic                    i_last,
    output logic                    empty,
    input  logic                    pop,
    output logic [MagW-1:0]         o_min_mag,
    output logic [MagW-1:0]         o_max_mag,
    output logic [MagW-1:0]         o_mean_mag,
    output logic [MagW-1:0]         o_std_dev
);
    logic    sv, sr, rv;
    t_stats  snap;
    t_result res;

    vms_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_vec_x, .i_vec_y, .i_vec_z, .i_last,
        .o_snap_valid(sv), .i_snap_ready(sr), .o_snap(snap)
    );

    vms_back u_back (
        .i_clk, .i_rst_n, .i_snap_valid(sv), .o_snap_ready(sr), .i_snap(snap),
        .o_res_valid(rv), .i_res_ready(pop), .o_res(res)
    );

    assign empty      = !rv;
    assign o_min_mag  = res.min_mag;
    assign o_max_mag  = res.max_mag;
    assign o_mean_mag = res.mean_mag;
    assign o_std_dev  = res.std_dev;

    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_min_mag <= o_max_mag) else $error("min above max");
    a_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_mean_mag <= o_max_mag) else $error("mean above max");
    a_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_mean_mag >= o_min_mag) else $error("mean below min");
endmodule

/* rtl/core/vms_front.sv */
// Front: 16-stage pipelined square root of x^2+y^2+z^2 and statistics accumulation.
// Uses vms_pkg. Emits a snapshot of the statistics on each last word.
`timescale 1ns / 1ps
module vms_front
    import vms_pkg::*;
#(
    parameter int MAX_POINTS = 16777216
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic signed [CompW-1:0] i_vec_x,
    input  logic signed [CompW-1:0] i_vec_y,
    input  logic signed [CompW-1:0] i_vec_z,
    input  logic                    i_last,
    output logic                    o_snap_valid,
    input  logic                    i_snap_ready,
    output t_stats                  o_snap
);
    localparam int Stg = MagW;
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_POINTS);

    // stage 0: squares
    logic            r_v0, r_l0;
    logic [SqW-1:0]  r_sq0;
    // root pipeline
    logic [Stg:0]            r_v, r_l;
    logic [SqW-1:0]          r_rem [Stg+1];
    logic [MagW-1:0]         r_root [Stg+1];
    logic                    stall;
    t_stats                  r_st, n_st;
    logic                    r_sv;
    t_stats                  r_snap;
    logic [MagW-1:0]         m;
    logic [2*MagW-1:0]       msq;
    logic                    take;

    assign stall  = r_sv && !i_snap_ready && r_v[Stg] && r_l[Stg];
    assign o_full = stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v  <= '0;
        end else if (!stall) begin
            r_v0 <= i_push;
            r_v  <= {r_v[Stg-1:0], r_v0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_l0  <= i_last;
            r_sq0 <= SqW'(32'(i_vec_x * i_vec_x)) + SqW'(32'(i_vec_y * i_vec_y))
                   + SqW'(32'(i_vec_z * i_vec_z));
            r_l[0]    <= r_l0;
            r_rem[0]  <= r_sq0;
            r_root[0] <= '0;
            for (int s = 0; s < Stg; s++) begin
                logic [MagW-1:0]   t;
                logic [2*MagW-1:0] tt;
                t  = r_root[s] | MagW'(1 << (Stg-1-s));
                tt = t * t;
                r_l[s+1]    <= r_l[s];
                r_rem[s+1]  <= r_rem[s];
                r_root[s+1] <= (SqW'(tt) <= r_rem[s]) ? t : r_root[s];
            end
        end
    end

    assign m    = r_root[Stg];
    assign msq  = m * m;
    assign take = r_v[Stg] && !stall;

    always_comb begin
        n_st = r_st;
        if (r_st.n < MaxCnt) begin
            if (m < r_st.mn) n_st.mn = m;
            if (m > r_st.mx) n_st.mx = m;
            n_st.sum = r_st.sum + SumW'(m);
            n_st.ssq = r_st.ssq + SsqW'(msq);
            n_st.n   = r_st.n + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{mn: '1, mx: '0, sum: '0, ssq: '0, n: '0};
            r_sv <= 1'b0;
        end else begin
            if (take && r_l[Stg]) begin
                r_sv <= 1'b1;
            end else if (i_snap_ready) begin
                r_sv <= 1'b0;
            end
            if (take) begin
                if (r_l[Stg]) begin
                    r_st   <= '{mn: '1, mx: '0, sum: '0, ssq: '0, n: '0};
                    r_snap <= n_st;
                end else begin
                    r_st <= n_st;
                end
            end
        end
    end

    assign o_snap_valid = r_sv;
    assign o_snap       = r_snap;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.n <= MaxCnt) else $error("count above limit");
    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv && !i_snap_ready |=> r_sv && $stable(r_snap))
        else $error("snapshot lost");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |-> r_sv) else $error("stall without pending snapshot");
endmodule

/* rtl/core/vms_back.sv */
// Back: mean by restoring division, std dev by bit-serial root over 97-bit math.
// Uses vms_pkg. One statistics snapshot at a time, results to an output register.
`timescale 1ns / 1ps
module vms_back
    import vms_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_snap_valid,
    output logic          o_snap_ready,
    input  t_stats        i_snap,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_result       o_res
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_PA = 7'b0000010, S_PB = 7'b0000100,
        S_DIV  = 7'b0001000, S_ROOT = 7'b0010000, S_SQ = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state              r_state;
    t_stats              r_s;
    logic [CntW-1:0]     nn;
    logic [5:0]          r_i;
    logic [SumW-1:0]     r_q;
    logic [CntW:0]       r_r;
    logic [CntW:0]       rr;
    logic [DW-1:0]       r_d, r_acc;
    logic [MagW-1:0]     r_sd;
    logic [MagW-1:0]     t;
    logic [MagW+CntW-1:0] r_tn;
    logic [DW-1:0]       r_p;
    logic [3:0]          r_b;
    t_result             r_res;
    logic                r_rv;
    logic [MagW+CntW-1:0] tn;

    assign nn = (r_s.n == '0) ? CntW'(1) : r_s.n;
    assign rr = {r_r[CntW-1:0], r_q[SumW-1]};
    assign t  = r_sd | (MagW'(1) << r_b);
    assign tn = t * nn;
    assign o_snap_ready = r_state == S_IDLE;
    assign o_res_valid  = r_rv;
    assign o_res        = r_res;

    // shift-add products: n*ssq over 25 steps, sum*sum over 40 steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv    <= 1'b0;
        end else begin
            if (r_rv && i_res_ready) r_rv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_snap_valid) begin
                        r_s     <= i_snap;
                        r_acc   <= '0;
                        r_i     <= '0;
                        r_state <= S_PA;
                    end
                end
                S_PA: begin // acc += n*ssq, one bit of n per cycle
                    if (nn[r_i[4:0]]) r_acc <= r_acc + (DW'(r_s.ssq) << r_i[4:0]);
                    if (r_i == 6'(CntW-1)) begin
                        r_i <= '0; r_p <= '0; r_state <= S_PB;
                    end else r_i <= r_i + 1'b1;
                end
                S_PB: begin // p = sum*sum, one bit per cycle
                    if (r_s.sum[r_i]) r_p <= r_p + (DW'(r_s.sum) << r_i);
                    if (r_i == 6'(SumW-1)) begin
                        r_i <= '0; r_q <= r_s.sum; r_r <= '0; r_state <= S_DIV;
                    end else r_i <= r_i + 1'b1;
                end
                S_DIV: begin
                    if (r_i == 6'd0) r_d <= r_acc - r_p;
                    if (rr >= {1'b0, nn}) begin
                        r_r <= rr - {1'b0, nn};
                        r_q <= {r_q[SumW-2:0], 1'b1};
                    end else begin
                        r_r <= rr;
                        r_q <= {r_q[SumW-2:0], 1'b0};
                    end
                    if (r_i == 6'(SumW-1)) begin
                        r_sd <= '0; r_b <= 4'(MagW-1); r_state <= S_ROOT;
                    end else r_i <= r_i + 1'b1;
                end
                S_ROOT: begin // register t*n, then square serially
                    r_tn <= tn;
                    r_p  <= '0;
                    r_i  <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_tn[r_i]) r_p <= r_p + (DW'(r_tn) << r_i);
                    if (r_i == 6'(MagW+CntW-1)) begin
                        r_state <= S_OUT;
                    end else r_i <= r_i + 1'b1;
                end
                S_OUT: begin
                    if (r_p <= r_d) r_sd <= t;
                    if (r_b == '0) begin
                        if (!r_rv || i_res_ready) begin
                            r_res.min_mag  <= r_s.mn;
                            r_res.max_mag  <= r_s.mx;
                            r_res.mean_mag <= r_q[MagW-1:0];
                            r_res.std_dev  <= (r_p <= r_d) ? t : r_sd;
                            r_rv    <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_b <= r_b - 1'b1;
                        r_state <= S_ROOT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv && !i_res_ready |=> r_rv && $stable(r_res)) else $error("result lost");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_snap_valid && o_snap_ready |=> r_state == S_PA) else $error("snapshot not taken");
endmodule
